### hw/rtl/sspm_pkg.sv
`timescale 1ns / 1ps

package sspm_pkg;

    localparam int          MAX_SLOTS_DEF = 16;
    localparam logic [33:0] MAX_BYTES_DEF = 34'h2_0000_0000;

    localparam int REQ_W     = 34;
    localparam int IDX_W     = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_RELEASED  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_CLOSING   = 3'd3,
        ST_NO_SLOT   = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    new_slot;
        logic    pop_rd;
        logic    cap_rd_pop;
        logic    grow_init;
        logic    grow_step;
        logic    grow_commit;
        logic    rel_rd;
        logic    rel_apply;
        logic    load_out;
        status_t code;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_release;
        logic too_large;
        logic closing;
        logic stack_empty;
        logic pool_full;
        logic rel_bad;
        logic grow_done;
        logic out_busy;
    } dp_stat_t;

endpackage

### hw/rtl/staging_slot_pool_manager.sv
`timescale 1ns / 1ps

// Slot pool manager with a LIFO free list: each beat on the s_ channel either acquires a
// slot for request_bytes or releases slot_index, and yields exactly one result beat on the
// m_ channel. One item is in flight at a time: a refused acquire, an ignored release, or
// an acquire that opens a fresh slot goes from decode straight to finish; a release that
// frees a slot passes through decode, a capacity-table read and an apply state; an acquire
// that reuses a freed slot passes through the registered reads of the free stack and
// capacity table and the doubling loop, which steps once per cycle. The output register
// lets the next item be accepted while a result beat waits on m_ready.
// Writing cfg_data as 1 refuses every acquire.
module staging_slot_pool_manager #(
    parameter int                         MAX_SLOTS = sspm_pkg::MAX_SLOTS_DEF,
    parameter logic [sspm_pkg::REQ_W-1:0] MAX_BYTES = sspm_pkg::MAX_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [sspm_pkg::REQ_W-1:0]     s_request_bytes,
    input  logic [sspm_pkg::IDX_W-1:0]     s_slot_index,
    input  logic                           s_poisoned,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [sspm_pkg::IDX_W-1:0]     m_granted_slot,
    output logic [sspm_pkg::REQ_W-1:0]     m_granted_capacity,
    output logic [sspm_pkg::CNT_OUT_W-1:0] m_idle_slots,
    output logic [sspm_pkg::CNT_OUT_W-1:0] m_backed_slots,
    output logic [sspm_pkg::CNT_OUT_W-1:0] m_active_slots
);

    sspm_pkg::ctl_cmd_t cmd;
    sspm_pkg::dp_stat_t stat;

    sspm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sspm_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_operation        (s_operation),
        .s_request_bytes    (s_request_bytes),
        .s_slot_index       (s_slot_index),
        .s_poisoned         (s_poisoned),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_granted_slot     (m_granted_slot),
        .m_granted_capacity (m_granted_capacity),
        .m_idle_slots       (m_idle_slots),
        .m_backed_slots     (m_backed_slots),
        .m_active_slots     (m_active_slots)
    );

endmodule

### hw/rtl/sspm_ram.sv
`timescale 1ns / 1ps

module sspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sspm_ctrl.sv
`timescale 1ns / 1ps

module sspm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sspm_pkg::dp_stat_t  stat,
    output sspm_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_STACK_RD  = 7'b0000100,
        S_CAP_RD    = 7'b0001000,
        S_GROW      = 7'b0010000,
        S_REL_APPLY = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    sspm_pkg::status_t code_reg;
    sspm_pkg::status_t code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= sspm_pkg::ST_GRANTED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_release) begin
                    if (stat.rel_bad) begin
                        code_next  = sspm_pkg::ST_IGNORED;
                        state_next = S_FINISH;
                    end else begin
                        cmd.rel_rd = 1'b1;
                        state_next = S_REL_APPLY;
                    end
                end else if (stat.too_large) begin
                    code_next  = sspm_pkg::ST_TOO_LARGE;
                    state_next = S_FINISH;
                end else if (stat.closing) begin
                    code_next  = sspm_pkg::ST_CLOSING;
                    state_next = S_FINISH;
                end else if (stat.stack_empty) begin
                    if (stat.pool_full) begin
                        code_next = sspm_pkg::ST_NO_SLOT;
                    end else begin
                        cmd.new_slot = 1'b1;
                        code_next    = sspm_pkg::ST_GRANTED;
                    end
                    state_next = S_FINISH;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_STACK_RD;
                end
            end
            S_STACK_RD: begin
                cmd.cap_rd_pop = 1'b1;
                state_next     = S_CAP_RD;
            end
            S_CAP_RD: begin
                cmd.grow_init = 1'b1;
                state_next    = S_GROW;
            end
            S_GROW: begin
                if (stat.grow_done) begin
                    cmd.grow_commit = 1'b1;
                    code_next       = sspm_pkg::ST_GRANTED;
                    state_next      = S_FINISH;
                end else begin
                    cmd.grow_step = 1'b1;
                end
            end
            S_REL_APPLY: begin
                cmd.rel_apply = 1'b1;
                code_next     = sspm_pkg::ST_RELEASED;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sspm_datapath.sv
`timescale 1ns / 1ps

module sspm_datapath #(
    parameter int                       MAX_SLOTS = sspm_pkg::MAX_SLOTS_DEF,
    parameter logic [sspm_pkg::REQ_W-1:0] MAX_BYTES = sspm_pkg::MAX_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sspm_pkg::ctl_cmd_t                cmd,
    output sspm_pkg::dp_stat_t                stat,
    input  logic                              s_operation,
    input  logic [sspm_pkg::REQ_W-1:0]        s_request_bytes,
    input  logic [sspm_pkg::IDX_W-1:0]        s_slot_index,
    input  logic                              s_poisoned,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [sspm_pkg::IDX_W-1:0]        m_granted_slot,
    output logic [sspm_pkg::REQ_W-1:0]        m_granted_capacity,
    output logic [sspm_pkg::CNT_OUT_W-1:0]    m_idle_slots,
    output logic [sspm_pkg::CNT_OUT_W-1:0]    m_backed_slots,
    output logic [sspm_pkg::CNT_OUT_W-1:0]    m_active_slots
);

    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int IDX_EXT_W = (SLOT_W > sspm_pkg::IDX_W) ? SLOT_W : sspm_pkg::IDX_W;
    localparam int CNT_EXT_W = (CNT_W > sspm_pkg::CNT_OUT_W) ? CNT_W : sspm_pkg::CNT_OUT_W;
    localparam logic [sspm_pkg::REQ_W-1:0] HALF_BYTES = MAX_BYTES >> 1;
    localparam logic [CNT_W-1:0]           SLOT_LIMIT = CNT_W'(MAX_SLOTS);

    logic                           op_reg;
    logic [sspm_pkg::REQ_W-1:0]     req_reg;
    logic [sspm_pkg::IDX_W-1:0]     idx_reg;
    logic                           poison_reg;
    logic                           closing_reg;
    logic [CNT_W-1:0]               depth_reg;
    logic [CNT_W-1:0]               opened_reg;
    logic [CNT_W-1:0]               active_reg;
    logic [CNT_W-1:0]               backed_reg;
    logic [MAX_SLOTS-1:0]           marks_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [sspm_pkg::REQ_W-1:0]     grow_reg;
    logic                           back_inc_reg;
    logic                           m_valid_reg;
    logic [2:0]                     status_reg;
    logic [sspm_pkg::IDX_W-1:0]     gslot_reg;
    logic [sspm_pkg::REQ_W-1:0]     gcap_reg;
    logic [sspm_pkg::CNT_OUT_W-1:0] idle_out_reg;
    logic [sspm_pkg::CNT_OUT_W-1:0] backed_out_reg;
    logic [sspm_pkg::CNT_OUT_W-1:0] active_out_reg;

    logic [IDX_EXT_W-1:0]           idx_ext;
    logic [SLOT_W-1:0]              rel_slot;
    logic [IDX_EXT_W-1:0]           slot_ext;
    logic [CNT_EXT_W-1:0]           depth_ext;
    logic [CNT_EXT_W-1:0]           backed_ext;
    logic [CNT_EXT_W-1:0]           active_ext;
    logic                           granted;

    logic                           cap_we;
    logic [SLOT_W-1:0]              cap_waddr;
    logic [sspm_pkg::REQ_W-1:0]     cap_wdata;
    logic                           cap_re;
    logic [SLOT_W-1:0]              cap_raddr;
    logic [sspm_pkg::REQ_W-1:0]     cap_rdata;
    logic                           stk_we;
    logic [SLOT_W-1:0]              stk_waddr;
    logic [SLOT_W-1:0]              stk_raddr;
    logic [SLOT_W-1:0]              stk_rdata;

    assign idx_ext  = IDX_EXT_W'(idx_reg);
    assign rel_slot = idx_ext[SLOT_W-1:0];
    assign slot_ext = IDX_EXT_W'(slot_reg);
    assign depth_ext  = CNT_EXT_W'(depth_reg);
    assign backed_ext = CNT_EXT_W'(backed_reg);
    assign active_ext = CNT_EXT_W'(active_reg);
    assign granted  = (cmd.code == sspm_pkg::ST_GRANTED);

    assign stat.is_release  = op_reg;
    assign stat.too_large   = (req_reg > MAX_BYTES);
    assign stat.closing     = closing_reg;
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.pool_full   = (opened_reg >= SLOT_LIMIT);
    assign stat.rel_bad     = (32'(idx_reg) >= 32'(opened_reg)) || !marks_reg[rel_slot];
    assign stat.grow_done   = (grow_reg >= req_reg);
    assign stat.out_busy    = m_valid_reg && !m_ready;

    assign cap_we    = cmd.new_slot || cmd.grow_commit || (cmd.rel_apply && poison_reg);
    assign cap_waddr = cmd.new_slot ? SLOT_W'(opened_reg) : slot_reg;
    assign cap_wdata = cmd.new_slot ? req_reg : (cmd.grow_commit ? grow_reg : '0);
    assign cap_re    = cmd.cap_rd_pop || cmd.rel_rd;
    assign cap_raddr = cmd.cap_rd_pop ? stk_rdata : rel_slot;

    assign stk_we    = cmd.rel_apply && (depth_reg < SLOT_LIMIT);
    assign stk_waddr = SLOT_W'(depth_reg);
    assign stk_raddr = SLOT_W'(depth_reg - CNT_W'(1));

    sspm_ram #(
        .WIDTH (sspm_pkg::REQ_W),
        .DEPTH (MAX_SLOTS)
    ) u_cap_ram (
        .aclk  (aclk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .re    (cap_re),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    sspm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (slot_reg),
        .re    (cmd.pop_rd),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_operation;
            req_reg    <= s_request_bytes;
            idx_reg    <= s_slot_index;
            poison_reg <= s_poisoned;
        end
        if (cmd.new_slot) begin
            slot_reg <= SLOT_W'(opened_reg);
            grow_reg <= req_reg;
        end
        if (cmd.cap_rd_pop) begin
            slot_reg <= stk_rdata;
        end
        if (cmd.rel_rd) begin
            slot_reg <= rel_slot;
        end
        if (cmd.grow_init) begin
            if (cap_rdata >= req_reg) begin
                grow_reg     <= cap_rdata;
                back_inc_reg <= 1'b0;
            end else begin
                grow_reg     <= (cap_rdata == '0) ? req_reg : cap_rdata;
                back_inc_reg <= (cap_rdata == '0);
            end
        end
        if (cmd.grow_step) begin
            grow_reg <= (grow_reg > HALF_BYTES) ? req_reg
                                                : {grow_reg[sspm_pkg::REQ_W-2:0], 1'b0};
        end
        if (cmd.load_out) begin
            status_reg     <= cmd.code;
            gslot_reg      <= granted ? slot_ext[sspm_pkg::IDX_W-1:0] : '0;
            gcap_reg       <= granted ? grow_reg : '0;
            idle_out_reg   <= depth_ext[sspm_pkg::CNT_OUT_W-1:0];
            backed_out_reg <= backed_ext[sspm_pkg::CNT_OUT_W-1:0];
            active_out_reg <= active_ext[sspm_pkg::CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closing_reg <= 1'b0;
            depth_reg   <= '0;
            opened_reg  <= '0;
            active_reg  <= '0;
            backed_reg  <= '0;
            marks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                closing_reg <= cfg_data;
            end
            if (cmd.new_slot) begin
                opened_reg                      <= opened_reg + CNT_W'(1);
                active_reg                      <= active_reg + CNT_W'(1);
                marks_reg[SLOT_W'(opened_reg)] <= 1'b1;
                if (req_reg != '0) begin
                    backed_reg <= backed_reg + CNT_W'(1);
                end
            end
            if (cmd.pop_rd) begin
                depth_reg <= depth_reg - CNT_W'(1);
            end
            if (cmd.grow_commit) begin
                marks_reg[slot_reg] <= 1'b1;
                active_reg          <= active_reg + CNT_W'(1);
                if (back_inc_reg) begin
                    backed_reg <= backed_reg + CNT_W'(1);
                end
            end
            if (cmd.rel_apply) begin
                marks_reg[slot_reg] <= 1'b0;
                if (active_reg != '0) begin
                    active_reg <= active_reg - CNT_W'(1);
                end
                if (poison_reg && (cap_rdata != '0) && (backed_reg != '0)) begin
                    backed_reg <= backed_reg - CNT_W'(1);
                end
                if (depth_reg < SLOT_LIMIT) begin
                    depth_reg <= depth_reg + CNT_W'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_granted_slot     = gslot_reg;
    assign m_granted_capacity = gcap_reg;
    assign m_idle_slots       = idle_out_reg;
    assign m_backed_slots     = backed_out_reg;
    assign m_active_slots     = active_out_reg;

endmodule

### bench/staging_slot_pool_manager_tb.sv
`timescale 1ns / 1ps

module staging_slot_pool_manager_tb;

    localparam bit          OP_ACQUIRE  = 1'b0;
    localparam bit          OP_RELEASE  = 1'b1;
    localparam int          POOL_SLOTS  = sspm_pkg::MAX_SLOTS_DEF;
    localparam logic [33:0] BYTE_LIMIT  = sspm_pkg::MAX_BYTES_DEF;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          PHASES      = 6;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} burst_mode_t;

    typedef struct packed {
        sspm_pkg::status_t status;
        logic [3:0]        slot;
        logic [33:0]       cap;
        logic [4:0]        idle;
        logic [4:0]        backed;
        logic [4:0]        active;
    } pool_result_t;

    class slot_pool_scoreboard;
        bit [33:0]    capacity[POOL_SLOTS];
        bit           leased_mark[POOL_SLOTS];
        bit [3:0]     free_stack[POOL_SLOTS];
        int unsigned  depth = 0;
        int unsigned  opened = 0;
        int unsigned  leased = 0;
        int unsigned  backed = 0;
        bit           closing = 1'b0;
        pool_result_t expected_q[$];
        int           errors = 0;

        function bit [33:0] fitted_capacity(bit [33:0] cur, bit [33:0] need);
            bit [33:0] cap;
            cap = (cur == 0) ? need : cur;
            while (cap < need) begin
                if (cap > (BYTE_LIMIT >> 1))
                    return need;
                cap = cap << 1;
            end
            return cap;
        endfunction

        function sspm_pkg::status_t note_request(bit op, bit [33:0] req, bit [3:0] idx,
                                                 bit poison);
            pool_result_t r;
            int unsigned  s;
            bit [33:0]    nc;
            r = '0;
            if (op == OP_ACQUIRE) begin
                if (req > BYTE_LIMIT) begin
                    r.status = sspm_pkg::ST_TOO_LARGE;
                end else if (closing) begin
                    r.status = sspm_pkg::ST_CLOSING;
                end else if (depth == 0) begin
                    if (opened >= POOL_SLOTS) begin
                        r.status = sspm_pkg::ST_NO_SLOT;
                    end else begin
                        s = opened;
                        opened++;
                        capacity[s] = req;
                        leased_mark[s] = 1'b1;
                        leased++;
                        if (req != 0)
                            backed++;
                        r.status = sspm_pkg::ST_GRANTED;
                        r.slot = 4'(s);
                        r.cap = req;
                    end
                end else begin
                    depth--;
                    s = {28'd0, free_stack[depth]};
                    if (capacity[s] < req) begin
                        nc = fitted_capacity(capacity[s], req);
                        if (capacity[s] == 0 && nc != 0)
                            backed++;
                        capacity[s] = nc;
                    end
                    leased_mark[s] = 1'b1;
                    leased++;
                    r.status = sspm_pkg::ST_GRANTED;
                    r.slot = 4'(s);
                    r.cap = capacity[s];
                end
            end else begin
                if (idx >= opened || !leased_mark[idx]) begin
                    r.status = sspm_pkg::ST_IGNORED;
                end else begin
                    leased_mark[idx] = 1'b0;
                    if (leased != 0)
                        leased--;
                    if (poison) begin
                        if (capacity[idx] != 0 && backed != 0)
                            backed--;
                        capacity[idx] = '0;
                    end
                    if (depth < POOL_SLOTS) begin
                        free_stack[depth] = idx;
                        depth++;
                    end
                    r.status = sspm_pkg::ST_RELEASED;
                end
            end
            r.idle = 5'(depth);
            r.backed = 5'(backed);
            r.active = 5'(leased);
            expected_q.insert(expected_q.size(), r);
            return r.status;
        endfunction

        function int pick_leased();
            int c[$];
            for (int i = 0; i < POOL_SLOTS; i++)
                if (leased_mark[i])
                    c.insert(c.size(), i);
            if (c.size() == 0)
                return -1;
            return c[$urandom_range(0, c.size() - 1)];
        endfunction

        function void compare_field(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(pool_result_t got);
            pool_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("granted_slot", e.slot, got.slot);
            compare_field("granted_capacity", e.cap, got.cap);
            compare_field("idle_slots", e.idle, got.idle);
            compare_field("backed_slots", e.backed, got.backed);
            compare_field("active_slots", e.active, got.active);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [33:0] s_request_bytes;
    logic [3:0]  s_slot_index;
    logic        s_poisoned;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [3:0]  m_granted_slot;
    logic [33:0] m_granted_capacity;
    logic [4:0]  m_idle_slots;
    logic [4:0]  m_backed_slots;
    logic [4:0]  m_active_slots;

    slot_pool_scoreboard sb;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;

    staging_slot_pool_manager dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_request_bytes    (s_request_bytes),
        .s_slot_index       (s_slot_index),
        .s_poisoned         (s_poisoned),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_granted_slot     (m_granted_slot),
        .m_granted_capacity (m_granted_capacity),
        .m_idle_slots       (m_idle_slots),
        .m_backed_slots     (m_backed_slots),
        .m_active_slots     (m_active_slots)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    always @(posedge aclk) begin
        pool_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = sspm_pkg::status_t'(m_status);
            got.slot = m_granted_slot;
            got.cap = m_granted_capacity;
            got.idle = m_idle_slots;
            got.backed = m_backed_slots;
            got.active = m_active_slots;
            sb.check_result(got);
        end
    end

    task automatic send_beat(input bit op, input bit [33:0] req, input bit [3:0] idx,
                             input bit poison, output sspm_pkg::status_t st);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_request_bytes <= req;
        s_slot_index <= idx;
        s_poisoned <= poison;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        st = sb.note_request(op, req, idx, poison);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_closing(input bit value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.closing = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [33:0] random_bytes();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2, 3: return 34'($urandom_range(1, 64));
            4: return 34'($urandom_range(1, 4096));
            5: return 34'(1) << $urandom_range(0, 33);
            6: return {1'b0, 1'($urandom), 32'($urandom)};
            7: return BYTE_LIMIT - 34'($urandom_range(0, 3));
            8: return {1'b1, 1'($urandom), 32'($urandom)};
            default: return {2'b01, 32'($urandom)};
        endcase
    endfunction

    task automatic random_beat(input burst_mode_t mode, output sspm_pkg::status_t st);
        bit        op;
        bit [33:0] req;
        bit [3:0]  idx;
        bit        poison;
        int        roll;
        int        pick;
        roll = $urandom_range(0, 99);
        req = random_bytes();
        idx = 4'($urandom);
        poison = ($urandom_range(0, 99) < 30);
        case (mode)
            MODE_FILL: op = (roll < 10) ? OP_RELEASE : OP_ACQUIRE;
            MODE_DRAIN: op = (roll < 90) ? OP_RELEASE : OP_ACQUIRE;
            MODE_MIXED: op = (roll < 50) ? OP_RELEASE : OP_ACQUIRE;
            default: op = 1'($urandom);
        endcase
        if (op == OP_RELEASE && mode != MODE_NOISE) begin
            pick = sb.pick_leased();
            if (pick >= 0 && $urandom_range(0, 99) < 90)
                idx = 4'(pick);
        end
        send_beat(op, req, idx, poison, st);
    endtask

    task automatic run_phase(input int items);
        int                counted;
        int                burst_left;
        int                roll;
        burst_mode_t       mode;
        sspm_pkg::status_t st;
        counted = 0;
        burst_left = 0;
        mode = MODE_FILL;
        while (counted < items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(4, 24);
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    mode = MODE_FILL;
                else if (roll < 55)
                    mode = MODE_DRAIN;
                else if (roll < 90)
                    mode = MODE_MIXED;
                else
                    mode = MODE_NOISE;
            end
            burst_left--;
            random_beat(mode, st);
            counted++;
        end
    endtask

    initial begin
        bit                phase_closing[PHASES];
        int                phase_items[PHASES];
        sspm_pkg::status_t st;

        phase_closing = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        phase_items = '{330, 330, 100, 330, 330, 330};
        sb = new;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_ACQUIRE;
        s_request_bytes = '0;
        s_slot_index = '0;
        s_poisoned = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Opening, oversized requests, bad releases, regrowth and the half-limit cutoff.
        write_closing(1'b0);
        send_beat(OP_ACQUIRE, 34'd0, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, BYTE_LIMIT, 4'd15, 1'b1, st);
        send_beat(OP_ACQUIRE, 34'h3_FFFF_FFFF, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, BYTE_LIMIT + 34'd1, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, 34'd3, 4'd0, 1'b0, st);
        send_beat(OP_RELEASE, 34'h3_FFFF_FFFF, 4'd2, 1'b0, st);
        send_beat(OP_RELEASE, 34'd0, 4'd2, 1'b1, st);
        send_beat(OP_RELEASE, 34'd0, 4'd15, 1'b1, st);
        send_beat(OP_ACQUIRE, BYTE_LIMIT, 4'd0, 1'b0, st);
        send_beat(OP_RELEASE, 34'd0, 4'd0, 1'b1, st);
        send_beat(OP_RELEASE, 34'd0, 4'd1, 1'b1, st);
        send_beat(OP_ACQUIRE, 34'd100, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, 34'd5, 4'd0, 1'b0, st);
        send_beat(OP_RELEASE, 34'd0, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, 34'd37, 4'd0, 1'b0, st);

        settle();
        write_closing(1'b1);
        send_beat(OP_ACQUIRE, 34'd7, 4'd0, 1'b0, st);
        send_beat(OP_ACQUIRE, 34'h3_FFFF_FFFF, 4'd0, 1'b0, st);
        send_beat(OP_RELEASE, 34'd0, 4'd0, 1'b0, st);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_closing(phase_closing[p]);
            quiet = (p == 1);
            if (p == 3)
                hold_request = 1'b1;
            run_phase(phase_items[p]);
            settle();
        end
        write_closing(1'b0);

        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/sspm_pkg.sv
hw/rtl/sspm_ram.sv
hw/rtl/sspm_ctrl.sv
hw/rtl/sspm_datapath.sv
hw/rtl/staging_slot_pool_manager.sv
bench/staging_slot_pool_manager_tb.sv
